// ----- rtl/core/dtds_pkg.sv -----
// Package for the dependency scoreboard: sizes, codes and sequencer states.
`default_nettype none
package dtds_pkg;
   localparam int MaxTasks = 64;
   localparam int IdW = $clog2(MaxTasks);
   localparam int CntW = $clog2(MaxTasks + 1);

   typedef enum logic [2:0] {
      ACT_ADD_EDGE = 3'd0,
      ACT_MARK_DONE = 3'd1,
      ACT_START = 3'd2,
      ACT_FINISH = 3'd3,
      ACT_TAKE = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ERR_OK = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_EMPTY = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      CSR_MAX_FAILURES = 2'd0,
      CSR_TRIES_ALLOWED = 2'd1,
      CSR_TASK_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_FLUSH_READ,
      ST_FLUSH_POP,
      ST_RESULT
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/core/dtds_if.sv -----
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface dtds_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [5:0] task_id;
   logic [5:0] other_task;
   logic       run_failed;
   modport source (output valid, action, task_id, other_task, run_failed, input ready);
   modport sink (input valid, action, task_id, other_task, run_failed, output ready);
endinterface

interface dtds_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] error_code;
   logic [5:0] task_out;
   logic       task_valid;
   logic       newly_done;
   logic       all_finished;
   logic       any_failed;
   logic       limit_reached;
   modport source (output valid, error_code, task_out, task_valid, newly_done,
                   all_finished, any_failed, limit_reached, input ready);
   modport sink (input valid, error_code, task_out, task_valid, newly_done,
                 all_finished, any_failed, limit_reached, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dtds_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module dtds_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/core/dag_task_dependency_scheduler_top.sv -----
// Top level of the dependency scoreboard task scheduler.
// Add edge, mark done, take next ready, retry and unused actions: the request beat is latched and
// executed in ST_EXEC, the response beat is held in ST_RESULT, then ST_IDLE takes the next request beat.
// Start and release of children: one matrix row per cycle over all MaxTasks rows (ST_SCAN, ST_SCAN_LAST).
// A flush on reaching the failure limit pops each queued task through ST_FLUSH_READ and ST_FLUSH_POP.
// Synchronous active-high reset clears the scoreboard; a pass over all MaxTasks rows then zeroes the
// matrix and tries memories while the request side is held not ready.
`default_nettype none
module dag_task_dependency_scheduler_top
   import dtds_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   dtds_req_if.sink req,
   dtds_rsp_if.source rsp,
   input wire logic       csr_we,
   input wire logic [1:0] csr_index,
   input wire logic [7:0] csr_wdata
);
   state_type state_ff, state_in;

   logic [7:0]      max_fail_ff, tries_allow_ff;
   logic [CntW-1:0] task_count_ff;

   logic [MaxTasks-1:0] done_ff, done_in, pend_ff, pend_in;
   logic [7:0]          gfail_ff, gfail_in;

   logic [IdW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;

   // Latched request and response fields.
   logic [2:0]     act_ff;
   logic [IdW-1:0] tid_ff, oth_ff;
   logic           fail_ff;
   logic [IdW-1:0] scan_ff, scan_in, idx_ff;
   logic           start_mode_ff, start_mode_in;
   logic           eval_ff;
   logic [1:0]     err_ff, err_in;
   logic [IdW-1:0] tout_ff, tout_in;
   logic           tval_ff, tval_in, newly_ff, newly_in;

   // Memory ports.
   logic                mat_we;
   logic [IdW-1:0]      mat_wa, mat_ra;
   logic [MaxTasks-1:0] mat_wd, mat_rd;
   logic                tries_we;
   logic [IdW-1:0]      tries_wa, tries_ra;
   logic [7:0]          tries_wd, tries_rd;
   logic                fifo_we;
   logic [IdW-1:0]      fifo_wd, fifo_rd;

   dtds_ram #(.Width(MaxTasks), .Depth(MaxTasks)) u_matrix (
      .clock(clock), .wr_en(mat_we), .wr_addr(mat_wa), .wr_data(mat_wd),
      .rd_addr(mat_ra), .rd_data(mat_rd)
   );

   dtds_ram #(.Width(8), .Depth(MaxTasks)) u_tries (
      .clock(clock), .wr_en(tries_we), .wr_addr(tries_wa), .wr_data(tries_wd),
      .rd_addr(tries_ra), .rd_data(tries_rd)
   );

   dtds_ram #(.Width(IdW), .Depth(MaxTasks)) u_fifo (
      .clock(clock), .wr_en(fifo_we), .wr_addr(tail_ff), .wr_data(fifo_wd),
      .rd_addr(head_ff), .rd_data(fifo_rd)
   );

   logic [CntW-1:0] live;
   assign live = (task_count_ff > CntW'(MaxTasks)) ? CntW'(MaxTasks) : task_count_ff;

   logic tid_ok, oth_ok;
   assign tid_ok = {1'b0, tid_ff} < live;
   assign oth_ok = {1'b0, oth_ff} < live;

   // Shared row test on the row read in the previous cycle.
   logic row_ready, scan_hit;
   assign row_ready = (mat_rd & ~done_ff) == '0;
   assign scan_hit = start_mode_ff ?
                     (({1'b0, idx_ff} < live) && !done_ff[idx_ff] && row_ready) :
                     (mat_rd[tid_ff] && row_ready);

   logic [7:0] tries_inc, gfail_inc;
   assign tries_inc = (tries_rd == 8'hFF) ? tries_rd : tries_rd + 8'd1;
   assign gfail_inc = (gfail_ff == 8'hFF) ? gfail_ff : gfail_ff + 8'd1;

   logic fifo_full;
   assign fifo_full = count_ff == CntW'(MaxTasks);

   logic limit_now, limit_next;
   assign limit_now = (max_fail_ff != 8'd0) && (gfail_ff >= max_fail_ff);
   assign limit_next = (max_fail_ff != 8'd0) && (gfail_inc >= max_fail_ff);

   logic [IdW-1:0] head_nx, tail_nx;
   assign head_nx = (head_ff == IdW'(MaxTasks - 1)) ? '0 : head_ff + IdW'(1);
   assign tail_nx = (tail_ff == IdW'(MaxTasks - 1)) ? '0 : tail_ff + IdW'(1);

   // Read addresses: the request fields while idle, the scan pointer for the matrix while scanning.
   assign mat_ra = (state_ff == ST_IDLE) ? req.other_task :
                   ((state_ff == ST_SCAN) ? scan_ff : oth_ff);
   assign tries_ra = (state_ff == ST_IDLE) ? req.task_id : tid_ff;

   assign req.ready = state_ff == ST_IDLE;
   assign rsp.valid = state_ff == ST_RESULT;

   logic           push;
   logic [IdW-1:0] push_id;

   // Sequencer: next state and scoreboard updates.
   always_comb begin
      state_in = state_ff;
      done_in = done_ff;
      pend_in = pend_ff;
      gfail_in = gfail_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      start_mode_in = start_mode_ff;
      err_in = err_ff;
      tout_in = tout_ff;
      tval_in = tval_ff;
      newly_in = newly_ff;
      mat_we = 1'b0;
      mat_wa = oth_ff;
      mat_wd = mat_rd | (MaxTasks'(1) << tid_ff);
      tries_we = 1'b0;
      tries_wa = tid_ff;
      tries_wd = tries_inc;
      push = 1'b0;
      push_id = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            mat_we = 1'b1;
            mat_wa = scan_ff;
            mat_wd = '0;
            tries_we = 1'b1;
            tries_wa = scan_ff;
            tries_wd = '0;
            if (scan_ff == IdW'(MaxTasks - 1)) begin
               scan_in = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + IdW'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            err_in = ERR_OK;
            tval_in = 1'b0;
            tout_in = '0;
            newly_in = 1'b0;
            scan_in = '0;
            start_mode_in = 1'b0;
            state_in = ST_RESULT;
            case (act_ff)
               ACT_ADD_EDGE: begin
                  if (tid_ok && oth_ok) mat_we = 1'b1;
                  else err_in = ERR_RANGE;
               end
               ACT_MARK_DONE: begin
                  if (tid_ok) done_in[tid_ff] = 1'b1;
                  else err_in = ERR_RANGE;
               end
               ACT_START: begin
                  gfail_in = '0;
                  start_mode_in = 1'b1;
                  state_in = ST_SCAN;
               end
               ACT_TAKE: begin
                  if (count_ff == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     tval_in = 1'b1;
                     tout_in = fifo_rd;
                     head_in = head_nx;
                     count_in = count_ff - CntW'(1);
                  end
               end
               ACT_FINISH: begin
                  if (!tid_ok) begin
                     err_in = ERR_RANGE;
                  end else if (!fail_ff) begin
                     done_in[tid_ff] = 1'b1;
                     newly_in = 1'b1;
                     pend_in[tid_ff] = 1'b0;
                     state_in = limit_now ? ST_FLUSH_READ : ST_SCAN;
                  end else begin
                     tries_we = 1'b1;
                     if (tries_inc < tries_allow_ff) begin
                        push = 1'b1;
                        push_id = tid_ff;
                     end else begin
                        pend_in[tid_ff] = 1'b0;
                        gfail_in = gfail_inc;
                        state_in = limit_next ? ST_FLUSH_READ : ST_SCAN;
                     end
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (scan_ff == IdW'(MaxTasks - 1)) begin
               state_in = ST_SCAN_LAST;
            end else begin
               scan_in = scan_ff + IdW'(1);
            end
         end
         ST_SCAN_LAST: begin
            state_in = ST_RESULT;
         end
         ST_FLUSH_READ: begin
            if (count_ff == '0) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_FLUSH_POP;
            end
         end
         ST_FLUSH_POP: begin
            pend_in[fifo_rd] = 1'b0;
            head_in = head_nx;
            count_in = count_ff - CntW'(1);
            state_in = ST_FLUSH_READ;
         end
         ST_RESULT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // A scanned row that qualifies is queued in index order.
      if (eval_ff && scan_hit) begin
         push = 1'b1;
         push_id = idx_ff;
      end
      // A push into a full queue is dropped, but the task still counts as pending.
      if (push) begin
         pend_in[push_id] = 1'b1;
         if (!fifo_full) begin
            tail_in = tail_nx;
            count_in = count_ff + CntW'(1);
         end
      end
   end

   assign fifo_we = push && !fifo_full;
   assign fifo_wd = push_id;

   // State, scoreboard, configuration and request latch registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         max_fail_ff <= 8'd0;
         tries_allow_ff <= 8'd1;
         task_count_ff <= '0;
         done_ff <= '0;
         pend_ff <= '0;
         gfail_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         scan_ff <= '0;
         idx_ff <= '0;
         eval_ff <= 1'b0;
         start_mode_ff <= 1'b0;
         err_ff <= ERR_OK;
         tout_ff <= '0;
         tval_ff <= 1'b0;
         newly_ff <= 1'b0;
         act_ff <= ACT_ADD_EDGE;
         tid_ff <= '0;
         oth_ff <= '0;
         fail_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         pend_ff <= pend_in;
         gfail_ff <= gfail_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         scan_ff <= scan_in;
         idx_ff <= scan_ff;
         eval_ff <= state_ff == ST_SCAN;
         start_mode_ff <= start_mode_in;
         err_ff <= err_in;
         tout_ff <= tout_in;
         tval_ff <= tval_in;
         newly_ff <= newly_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_FAILURES: max_fail_ff <= csr_wdata;
               CSR_TRIES_ALLOWED: tries_allow_ff <= csr_wdata;
               CSR_TASK_COUNT: task_count_ff <= csr_wdata[CntW-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req.valid) begin
            act_ff <= req.action;
            tid_ff <= req.task_id;
            oth_ff <= req.other_task;
            fail_ff <= req.run_failed;
         end
      end
   end

   logic any_failed;
   always_comb begin
      any_failed = 1'b0;
      for (int t = 0; t < MaxTasks; t++) begin
         if (CntW'(t) < live && !done_ff[t]) any_failed = 1'b1;
      end
   end

   assign rsp.error_code = err_ff;
   assign rsp.task_out = tout_ff;
   assign rsp.task_valid = tval_ff;
   assign rsp.newly_done = newly_ff;
   assign rsp.all_finished = pend_ff == '0;
   assign rsp.any_failed = any_failed;
   assign rsp.limit_reached = limit_now;

   // Checks on the sequencer and FIFO bookkeeping.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxTasks)) else $error("FIFO count above depth");
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("request and response overlap");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("response dropped");
endmodule
`default_nettype wire

// ----- verif/dtds_scoreboard_checker.sv -----
// Checker for the dependency scoreboard: tracks task state, predicts and compares response beats.
`timescale 1ns / 100ps
module dtds_scoreboard_checker
   import dtds_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   dtds_req_if            req,
   dtds_rsp_if            rsp,
   input wire logic       csr_we,
   input wire logic [1:0] csr_index,
   input wire logic [7:0] csr_wdata,
   output int             failures
);
   typedef struct packed {
      logic [1:0] error_code;
      logic [5:0] task_out;
      logic       task_valid;
      logic       newly_done;
      logic       all_finished;
      logic       any_failed;
      logic       limit_reached;
   } rsp_beat_type;

   // Shadow copy of the scoreboard and its registers.
   logic [63:0] done_mask;
   logic [63:0] pending_mask;
   logic [63:0] parents_of [64];
   logic [7:0]  tries [64];
   logic [5:0]  ready_fifo [64];
   int          fifo_head, fifo_tail, fifo_count;
   logic [7:0]  fail_total;
   logic [7:0]  fail_limit;
   logic [7:0]  tries_limit;
   logic [6:0]  live_count;

   rsp_beat_type expected_beats[$];
   int           mismatch_count;

   function automatic bit parents_done(int c);
      return (parents_of[c] & ~done_mask) == 64'd0;
   endfunction

   function automatic bit limit_hit();
      return fail_limit != 0 && fail_total >= fail_limit;
   endfunction

   task automatic enqueue_ready(int t);
      if (fifo_count < MaxTasks) begin
         ready_fifo[fifo_tail] = t[5:0];
         fifo_tail = (fifo_tail + 1) % MaxTasks;
         fifo_count++;
      end
      pending_mask[t] = 1'b1;
   endtask

   task automatic dequeue_ready(output int t);
      t = ready_fifo[fifo_head];
      fifo_head = (fifo_head + 1) % MaxTasks;
      fifo_count--;
   endtask

   // Work out the response beat that one request beat causes.
   task automatic schedule_step(input logic [2:0] action, input int tid, input int other,
                                input logic failed, output rsp_beat_type r);
      int  n;
      int  t;
      bit  requeued;
      r = '0;
      r.error_code = ERR_OK;
      n = (live_count > MaxTasks) ? MaxTasks : live_count;
      case (action)
         ACT_ADD_EDGE: begin
            if (tid >= n || other >= n) r.error_code = ERR_RANGE;
            else parents_of[other][tid] = 1'b1;
         end
         ACT_MARK_DONE: begin
            if (tid >= n) r.error_code = ERR_RANGE;
            else done_mask[tid] = 1'b1;
         end
         ACT_START: begin
            fail_total = 0;
            for (int i = 0; i < n; i++)
               if (!done_mask[i] && parents_done(i)) enqueue_ready(i);
         end
         ACT_FINISH: begin
            if (tid >= n) begin
               r.error_code = ERR_RANGE;
            end else begin
               requeued = 0;
               if (!failed) begin
                  done_mask[tid] = 1'b1;
                  r.newly_done = 1'b1;
               end else begin
                  if (tries[tid] < 8'd255) tries[tid]++;
                  if (tries[tid] < tries_limit) begin
                     enqueue_ready(tid);
                     requeued = 1;
                  end else if (fail_total < 8'd255) begin
                     fail_total++;
                  end
               end
               if (!requeued) begin
                  pending_mask[tid] = 1'b0;
                  // Reaching the failure limit drains the queue; otherwise release children.
                  if (limit_hit()) begin
                     while (fifo_count != 0) begin
                        dequeue_ready(t);
                        pending_mask[t] = 1'b0;
                     end
                  end else begin
                     for (int c = 0; c < MaxTasks; c++)
                        if (parents_of[c][tid] && parents_done(c)) enqueue_ready(c);
                  end
               end
            end
         end
         ACT_TAKE: begin
            if (fifo_count == 0) begin
               r.error_code = ERR_EMPTY;
            end else begin
               dequeue_ready(t);
               r.task_out = t[5:0];
               r.task_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.all_finished = (pending_mask == 64'd0);
      for (int i = 0; i < n; i++)
         if (!done_mask[i]) r.any_failed = 1'b1;
      r.limit_reached = limit_hit();
   endtask

   task automatic report(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      rsp_beat_type got;
      if (reset) begin
         done_mask = '0;
         pending_mask = '0;
         for (int i = 0; i < MaxTasks; i++) begin
            parents_of[i] = '0;
            tries[i] = '0;
         end
         fifo_head = 0;
         fifo_tail = 0;
         fifo_count = 0;
         fail_total = 0;
         fail_limit = 0;
         tries_limit = 1;
         live_count = 0;
         expected_beats.delete();
         mismatch_count = 0;
      end else begin
         // Register writes are to land only while the block is idle; the writer must keep to that, not enforced here.
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_FAILURES:  fail_limit = csr_wdata;
               CSR_TRIES_ALLOWED: tries_limit = csr_wdata;
               CSR_TASK_COUNT:    live_count = csr_wdata[6:0];
               default: ;
            endcase
         end
         // Compare a response beat with the oldest prediction.
         if (rsp.valid && rsp.ready) begin
            got = {rsp.error_code, rsp.task_out, rsp.task_valid, rsp.newly_done,
                   rsp.all_finished, rsp.any_failed, rsp.limit_reached};
            if (expected_beats.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual %h", $realtime, got);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               report("error_code", want.error_code, got.error_code);
               report("task_out", want.task_out, got.task_out);
               report("task_valid", want.task_valid, got.task_valid);
               report("newly_done", want.newly_done, got.newly_done);
               report("all_finished", want.all_finished, got.all_finished);
               report("any_failed", want.any_failed, got.any_failed);
               report("limit_reached", want.limit_reached, got.limit_reached);
            end
         end
         // Predict the response of an accepted request beat.
         if (req.valid && req.ready) begin
            schedule_step(req.action, req.task_id, req.other_task, req.run_failed, want);
            expected_beats = {expected_beats, want};
         end
      end
      failures <= mismatch_count + expected_beats.size();
   end
endmodule

// ----- verif/dag_task_dependency_scheduler_top_tb.sv -----
// Testbench top: drives scheduler requests and registers, paces responses, gives the verdict.
`timescale 1ns / 100ps
module dag_task_dependency_scheduler_top_tb;
   import dtds_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   int         failures;

   dtds_req_if req ();
   dtds_rsp_if rsp ();

   dag_task_dependency_scheduler_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   dtds_scoreboard_checker checker_inst (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures)
   );

   int         sent_beats;
   int         taken_beats;
   logic [5:0] last_task;
   logic       last_valid;
   int         send_gap_pct;
   int         stall_pct;
   logic       hold_request;
   logic       hold_taken;
   int         hold_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_taken <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cycles <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Track what left the block, so the sender can follow popped tasks.
   always @(posedge clock) begin
      if (reset) begin
         taken_beats <= 0;
         last_task <= '0;
         last_valid <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         taken_beats <= taken_beats + 1;
         last_task <= rsp.task_out;
         last_valid <= rsp.task_valid;
      end
   end

   task automatic send_beat(int action, int tid, int other, int failed);
      while ($urandom_range(99) < send_gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= action[2:0];
      req.task_id <= tid[5:0];
      req.other_task <= other[5:0];
      req.run_failed <= failed[0];
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_beats++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (taken_beats != sent_beats) @(posedge clock);
   endtask

   // Registers are written only once every response has come back.
   task automatic write_registers(int max_fail, int tries, int count);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_FAILURES;
      csr_wdata <= max_fail[7:0];
      @(posedge clock);
      csr_index <= CSR_TRIES_ALLOWED;
      csr_wdata <= tries[7:0];
      @(posedge clock);
      csr_index <= CSR_TASK_COUNT;
      csr_wdata <= {1'b0, count[6:0]};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Pop one ready task and report its run; returns 0 when the queue was empty.
   task automatic take_and_finish(int fail_pct, output bit got_task);
      send_beat(ACT_TAKE, $urandom, $urandom, $urandom);
      wait_drained();
      got_task = last_valid;
      if (last_valid)
         send_beat(ACT_FINISH, last_task, $urandom, $urandom_range(99) < fail_pct);
   endtask

   initial begin
      bit   got;
      int   n;
      int   p;
      int   c;
      int   swap;
      int   round;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_MAX_FAILURES;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.action <= ACT_ADD_EDGE;
      req.task_id <= '0;
      req.other_task <= '0;
      req.run_failed <= 1'b0;
      hold_request <= 1'b0;
      send_gap_pct = 0;
      stall_pct = 0;
      sent_beats = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty task range, empty queue, unused actions.
      send_beat(ACT_ADD_EDGE, 0, 1, 0);
      send_beat(ACT_TAKE, 0, 0, 0);
      send_beat(5, 63, 63, 1);
      send_beat(7, 0, 0, 0);
      send_beat(ACT_START, 0, 0, 0);
      write_registers(1, 2, 4);
      // Duplicate edge, out-of-range child, a chain and a done task.
      send_beat(ACT_ADD_EDGE, 0, 1, 0);
      send_beat(ACT_ADD_EDGE, 0, 1, 0);
      send_beat(ACT_ADD_EDGE, 1, 2, 0);
      send_beat(ACT_ADD_EDGE, 0, 63, 0);
      send_beat(ACT_MARK_DONE, 3, 0, 0);
      send_beat(ACT_MARK_DONE, 63, 0, 0);
      send_beat(ACT_START, 0, 0, 0);
      // Fail once to requeue, then again to hit the failure limit and flush.
      take_and_finish(100, got);
      take_and_finish(100, got);
      send_beat(ACT_FINISH, 63, 0, 1);
      send_beat(ACT_START, 0, 0, 0);
      send_beat(ACT_START, 0, 0, 0);
      take_and_finish(0, got);
      take_and_finish(0, got);
      take_and_finish(0, got);
      write_registers(255, 0, 127);
      send_beat(ACT_FINISH, 5, 0, 1);
      send_beat(ACT_START, 0, 0, 0);
      take_and_finish(0, got);

      // Random scenarios: build a DAG, start, and run it down through the queue.
      round = 0;
      while (sent_beats < 1150) begin
         case (round % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 80; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 80; end
            default: begin send_gap_pct = 17; stall_pct = 17; end
         endcase
         n = 6 + round * 3;
         if (n > 64) n = $urandom_range(2, 64);
         if (round % 9 == 8) n = 64;
         write_registers(($urandom_range(3) == 0) ? 255 : $urandom_range(0, 3),
                         ($urandom_range(5) == 0) ? 255 : $urandom_range(0, 3), n);
         repeat ($urandom_range(0, 2 * n)) begin
            p = $urandom_range(0, n - 1);
            c = $urandom_range(0, n - 1);
            if (p > c) begin swap = p; p = c; c = swap; end
            if (p != c) send_beat(ACT_ADD_EDGE, p, c, $urandom);
         end
         if ($urandom_range(3) == 0) send_beat(ACT_MARK_DONE, $urandom_range(0, n - 1), 0, 0);
         repeat ($urandom_range(0, 2))
            send_beat($urandom, $urandom, $urandom, $urandom);
         send_beat(ACT_START, $urandom, $urandom, $urandom);
         if ($urandom_range(4) == 0) send_beat(ACT_START, 0, 0, 0);
         got = 1;
         for (int k = 0; k < 3 * n && got && sent_beats < 1150; k++)
            take_and_finish(45, got);
         // Long response hold-off once, with requests still being offered.
         if (round == 5) begin
            hold_request <= 1'b1;
            repeat (20) send_beat($urandom, $urandom, $urandom, $urandom);
         end
         round++;
      end

      wait_drained();
      repeat (300) @(posedge clock);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
